>>> src/adapter_ungapped_local_align_top_macros.svh
// Assertion macros for the adapter aligner checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ADAPTER_UNGAPPED_LOCAL_ALIGN_TOP_MACROS_SVH
`define ADAPTER_UNGAPPED_LOCAL_ALIGN_TOP_MACROS_SVH

// Same-cycle implication.
`define AULA_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aula check failed");

// Next-cycle implication.
`define AULA_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aula check failed");

`endif

>>> src/aula_pkg.sv
`default_nettype none

package aula_pkg;

    // Built-in adapter text
    localparam int SEQ_LEN = 33;

    localparam logic [8*SEQ_LEN-1:0] ADPT_TXT [2] = '{
        "AGATCGGAAGAGCGGTTCAGCAGGAATGCCGAG",
        "AGATCGGAAGAGCGTCGTGTAGGGAAAGAGTGT"
    };

    // Base codes
    localparam logic [2:0] BASE_A = 3'd0;
    localparam logic [2:0] BASE_C = 3'd1;
    localparam logic [2:0] BASE_G = 3'd2;
    localparam logic [2:0] BASE_T = 3'd3;
    localparam logic [2:0] BASE_N = 3'd4;

    // Scoring
    localparam int          SCORE_W    = 8;
    localparam logic [7:0]  MATCH_GAIN = 8'd5;
    localparam logic [7:0]  MISS_LOSS  = 8'd10;

    // Register indexes
    localparam logic [1:0] CFG_ADAPTER_SELECT  = 2'd0;
    localparam logic [1:0] CFG_SCORE_CUTOFF    = 2'd1;
    localparam logic [1:0] CFG_MIN_KEEP_LENGTH = 2'd2;
    localparam logic [1:0] CFG_TRIM_ENABLE     = 2'd3;

    // Register reset values
    localparam logic [7:0] RST_SCORE_CUTOFF    = 8'd50;
    localparam logic [7:0] RST_MIN_KEEP_LENGTH = 8'd50;

    // Read actions
    localparam logic [1:0] ACT_KEEP = 2'd0;
    localparam logic [1:0] ACT_TRIM = 2'd1;
    localparam logic [1:0] ACT_DROP = 2'd2;

    typedef struct packed {
        logic [7:0] base_char;
        logic       last_base;
    } t_in;

    typedef struct packed {
        logic       adapter_found;
        logic [7:0] best_score;
        logic [7:0] read_start;
        logic [7:0] read_end;
        logic [5:0] adp_first;
        logic [5:0] adp_last;
        logic [7:0] insert_size;
        logic [7:0] read_len;
        logic [1:0] read_action;
        logic       too_long;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic scan_done;
        logic out_free;
    } t_sts;

    function automatic logic [2:0] code_of(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            8'h41, 8'h61: code = BASE_A;  // A a
            8'h43, 8'h63: code = BASE_C;  // C c
            8'h47, 8'h67: code = BASE_G;  // G g
            8'h54, 8'h74: code = BASE_T;  // T t
            default:      code = BASE_N;
        endcase
        return code;
    endfunction

    // Adapter base code at 0-based column; columns past the text never match
    function automatic logic [2:0] adapter_code(input logic sel, input int col);
        logic [2:0] code;
        if (col >= SEQ_LEN) begin
            code = BASE_N;
        end else begin
            code = code_of(ADPT_TXT[sel][8*(SEQ_LEN-1-col) +: 8]);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

>>> src/aula_ctrl.sv
`default_nettype none

module aula_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_last_base,
    input  wire aula_pkg::t_sts i_sts,
    output aula_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);

    aula_pkg::t_state r_state, n_state;
    logic             r_last, n_last;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == aula_pkg::ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        unique case (r_state)
            aula_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_last_base;
                    if (!i_sts.full) begin
                        n_state = aula_pkg::ST_SCAN;
                    end else if (i_last_base) begin
                        n_state = aula_pkg::ST_EMIT;
                    end
                end
            end
            aula_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = r_last ? aula_pkg::ST_EMIT : aula_pkg::ST_IDLE;
                end
            end
            aula_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = aula_pkg::ST_IDLE;
                end
            end
            default: n_state = aula_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            aula_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            aula_pkg::ST_SCAN: o_cmd.scan = 1'b1;
            aula_pkg::ST_EMIT: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aula_pkg::ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

>>> src/aula_dp.sv
`default_nettype none

module aula_dp #(
    parameter int READ_MAX    = 128,
    parameter int ADAPTER_LEN = 33
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire aula_pkg::t_in  i_in_data,
    input  wire aula_pkg::t_cmd i_cmd,
    output aula_pkg::t_sts      o_sts,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output aula_pkg::t_out      o_out_data
);

    localparam int CW  = $clog2(READ_MAX + 1);
    localparam int CLW = $clog2(ADAPTER_LEN + 1);
    localparam int SW  = ((CW > CLW) ? CW : CLW) + 1;
    localparam int KW  = (SW > 8) ? SW : 8;
    localparam int IW  = (ADAPTER_LEN > 1) ? $clog2(ADAPTER_LEN) : 1;
    localparam int SCW = aula_pkg::SCORE_W;

    // Configuration
    logic           r_sel;
    logic [7:0]     r_cutoff;
    logic [7:0]     r_min_keep;
    logic           r_trim;

    // Diagonal cells
    logic [SCW-1:0] r_score [ADAPTER_LEN];
    logic [CW-1:0]  r_rs    [ADAPTER_LEN];
    logic [SCW-1:0] n_score [ADAPTER_LEN];
    logic [CW-1:0]  n_rs    [ADAPTER_LEN];

    // Read state
    logic [CW-1:0]  r_count;
    logic           r_over;
    logic [SCW-1:0] r_best;
    logic [CW-1:0]  r_row_end;
    logic [CLW-1:0] r_col_end;
    logic [CW-1:0]  r_row_start;
    logic [CLW-1:0] r_col_start;
    logic [IW-1:0]  r_idx;

    // Output register
    logic           r_out_valid;
    aula_pkg::t_out r_out, n_out;

    logic [2:0]     w_base;
    logic [CW-1:0]  w_row;
    logic [SCW-1:0] w_cur_score;
    logic [CW-1:0]  w_cur_rs;
    logic [CLW-1:0] w_cur_col;
    logic [SW-1:0]  w_cur_col_start;

    assign w_base = aula_pkg::code_of(i_in_data.base_char);
    assign w_row  = CW'(r_count + 1'b1);

    // Cell row: every diagonal advances by one on the incoming base
    for (genvar j = 0; j < ADAPTER_LEN; j++) begin : g_cell
        localparam logic [2:0] CODE0 = aula_pkg::adapter_code(1'b0, j);
        localparam logic [2:0] CODE1 = aula_pkg::adapter_code(1'b1, j);
        logic [2:0]     w_acode;
        logic [SCW-1:0] w_prev;
        logic [CW-1:0]  w_prev_rs;
        logic           w_match;

        if (j == 0) begin : g_edge
            assign w_prev    = '0;
            assign w_prev_rs = '0;
        end else begin : g_inner
            assign w_prev    = r_score[j-1];
            assign w_prev_rs = r_rs[j-1];
        end

        assign w_acode = r_sel ? CODE1 : CODE0;
        assign w_match = (w_base != aula_pkg::BASE_N) && (w_base == w_acode);

        always_comb begin
            if (w_match) begin
                n_score[j] = SCW'(w_prev + aula_pkg::MATCH_GAIN);
            end else if (w_prev > aula_pkg::MISS_LOSS) begin
                n_score[j] = SCW'(w_prev - aula_pkg::MISS_LOSS);
            end else begin
                n_score[j] = '0;
            end
            if (n_score[j] == '0) begin
                n_rs[j] = '0;
            end else if (w_prev != '0) begin
                n_rs[j] = w_prev_rs;
            end else begin
                n_rs[j] = w_row;
            end
        end
    end

    // Scan candidate, one column per cycle
    assign w_cur_score     = r_score[r_idx];
    assign w_cur_rs        = r_rs[r_idx];
    assign w_cur_col       = CLW'(r_idx + 1'b1);
    assign w_cur_col_start = SW'(SW'(w_cur_col) + SW'(w_cur_rs) - SW'(r_count));

    // Result fields
    always_comb begin
        logic          found;
        logic [SW-1:0] rs_x;
        logic [SW-1:0] as_x;
        logic [SW-1:0] ins;
        found = (r_best >= r_cutoff);
        rs_x  = SW'(r_row_start);
        as_x  = SW'(r_col_start);
        ins   = (rs_x > as_x) ? SW'(rs_x - as_x) : '0;
        n_out = '0;
        n_out.adapter_found = found;
        n_out.best_score    = 8'(r_best);
        n_out.read_len      = 8'(r_count);
        n_out.too_long      = r_over;
        if (found) begin
            if (r_best != '0) begin
                n_out.read_start  = 8'(r_row_start);
                n_out.read_end    = 8'(r_row_end);
                n_out.adp_first   = 6'(r_col_start);
                n_out.adp_last    = 6'(r_col_end);
                n_out.insert_size = 8'(ins);
                n_out.read_action = (r_trim && (KW'(ins) >= KW'(r_min_keep)))
                                    ? aula_pkg::ACT_TRIM : aula_pkg::ACT_DROP;
            end else begin
                n_out.read_action = (r_trim && (r_min_keep == 8'd0))
                                    ? aula_pkg::ACT_TRIM : aula_pkg::ACT_DROP;
            end
        end else begin
            n_out.read_action = aula_pkg::ACT_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_cutoff    <= aula_pkg::RST_SCORE_CUTOFF;
            r_min_keep  <= aula_pkg::RST_MIN_KEEP_LENGTH;
            r_trim      <= 1'b0;
            r_count     <= '0;
            r_over      <= 1'b0;
            r_best      <= '0;
            r_row_end   <= '0;
            r_col_end   <= '0;
            r_row_start <= '0;
            r_col_start <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ADAPTER_LEN; k++) begin
                r_score[k] <= '0;
                r_rs[k]    <= '0;
            end
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aula_pkg::CFG_ADAPTER_SELECT:  r_sel      <= i_cfg_wdata[0];
                    aula_pkg::CFG_SCORE_CUTOFF:    r_cutoff   <= i_cfg_wdata;
                    aula_pkg::CFG_MIN_KEEP_LENGTH: r_min_keep <= i_cfg_wdata;
                    aula_pkg::CFG_TRIM_ENABLE:     r_trim     <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // Base transfer: advance the cells or flag overlong
            if (i_cmd.accept) begin
                if (!o_sts.full) begin
                    r_count <= w_row;
                    r_idx   <= '0;
                    for (int k = 0; k < ADAPTER_LEN; k++) begin
                        r_score[k] <= n_score[k];
                        r_rs[k]    <= n_rs[k];
                    end
                end else begin
                    r_over <= 1'b1;
                end
            end

            // Best-cell scan, columns ascending, strict greater wins
            if (i_cmd.scan) begin
                r_idx <= IW'(r_idx + 1'b1);
                if (w_cur_score > r_best) begin
                    r_best      <= w_cur_score;
                    r_row_end   <= r_count;
                    r_col_end   <= w_cur_col;
                    r_row_start <= w_cur_rs;
                    r_col_start <= CLW'(w_cur_col_start);
                end
            end

            // Load result and clear the read; otherwise drop valid on transfer out
            if (i_cmd.emit) begin
                r_out       <= n_out;
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_over      <= 1'b0;
                r_best      <= '0;
                r_row_end   <= '0;
                r_col_end   <= '0;
                r_row_start <= '0;
                r_col_start <= '0;
                for (int k = 0; k < ADAPTER_LEN; k++) begin
                    r_score[k] <= '0;
                    r_rs[k]    <= '0;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.full      = (r_count == CW'(READ_MAX));
    assign o_sts.scan_done = (r_idx == IW'(ADAPTER_LEN - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

`default_nettype wire

>>> src/adapter_ungapped_local_align_top.sv
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_ready   i_in_data  (aula_pkg::t_in)
// out       output     o_out_valid/i_out_ready o_out_data (aula_pkg::t_out)
// cfg       input      i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// A scored base first advances all diagonal cells, then scans the adapter
// columns in ascending order in the best-cell scan.
// The last base of a read then loads the result register; that load
// waits while a previous result is still held on the output.
// A base past READ_MAX is not scored but sets the overlong flag. Synchronous reset clears all state but o_out_data.
`default_nettype none

module adapter_ungapped_local_align_top #(
    parameter int READ_MAX    = 128,
    parameter int ADAPTER_LEN = 33
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire aula_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output aula_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata
);

    aula_pkg::t_cmd w_cmd;
    aula_pkg::t_sts w_sts;

    aula_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_base (i_in_data.last_base),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready)
    );

    aula_dp #(
        .READ_MAX    (READ_MAX),
        .ADAPTER_LEN (ADAPTER_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> src/aula_chk.sv
`default_nettype none
`include "adapter_ungapped_local_align_top_macros.svh"

module aula_chk #(
    parameter int READ_MAX = 128
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire aula_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire aula_pkg::t_out o_out_data
);

    // Result held until its transfer
    `AULA_AST_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // Accepting the last base drops input ready in the next cycle while the read finishes
    `AULA_AST_NXT(a_last_busy, i_in_valid && o_in_ready && i_in_data.last_base, !o_in_ready)

    // No hit: keep-whole action, zero read start, adapter end and insert size
    `AULA_AST_IMP(a_miss_zero, o_out_valid && !o_out_data.adapter_found,
        (o_out_data.read_action == aula_pkg::ACT_KEEP) && (o_out_data.read_start == 8'd0)
        && (o_out_data.adp_last == 6'd0) && (o_out_data.insert_size == 8'd0))

    // Hit: trim or drop, never keep whole
    `AULA_AST_IMP(a_hit_act, o_out_valid && o_out_data.adapter_found,
        (o_out_data.read_action == aula_pkg::ACT_TRIM)
        || (o_out_data.read_action == aula_pkg::ACT_DROP))

    // Overlong read reports saturated length
    `AULA_AST_IMP(a_long_len, o_out_valid && o_out_data.too_long,
        o_out_data.read_len == 8'(READ_MAX))

endmodule

bind adapter_ungapped_local_align_top aula_chk #(.READ_MAX(READ_MAX)) u_aula_chk (.*);

`default_nettype wire
